>>> hdl/isc_pkg.sv
package isc_pkg;

  localparam int COORD_W       = 24;
  localparam int FRAC_BITS     = 16;
  localparam int CUT_W         = 19;
  localparam int AXES          = 3;
  localparam int DIST_BINS     = 120;
  localparam int SPECIES_COUNT = 3;
  localparam int HIST_DEPTH    = SPECIES_COUNT * DIST_BINS;
  localparam int HIST_AW       = $clog2(HIST_DEPTH);
  localparam int BIN_W         = 32;
  localparam int CNT_W         = 6;
  localparam int SPEC_W        = 2;
  localparam int BSEL_W        = 7;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;
  localparam int PROD_W        = 2 * COORD_W;
  localparam int RR_W          = PROD_W + 2;
  localparam int RAD_W         = CUT_W + 1;
  localparam int SQR_W         = 2 * RAD_W;
  localparam int TENTH         = ((1 << FRAC_BITS) + 5) / 10;
  localparam int LIMIT_W       = 2 * FRAC_BITS + 6;
  localparam int SCALED_W      = LIMIT_W + 9;
  localparam int SQV_W         = 14;
  localparam int ROOT_W        = 7;
  localparam int ROOT_STEP_W   = $clog2(ROOT_W);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CUT_W-1:0]   cut_t;
  typedef logic [RAD_W-1:0]   rad_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [BIN_W-1:0]   bin_t;
  typedef logic [HIST_AW-1:0] haddr_t;

  localparam cnt_t   CNT_MAX    = '1;
  localparam coord_t SLAB_LO    = coord_t'(6 << FRAC_BITS);
  localparam coord_t SLAB_HI    = coord_t'(30 << FRAC_BITS);
  localparam logic [LIMIT_W-1:0] RDF_LIMIT2 = LIMIT_W'(36) << (2 * FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_X,
    REG_BOX_Y,
    REG_BOX_Z,
    REG_CUT_FIRST,
    REG_CUT_SECOND,
    REG_CUT_THIRD
  } cfg_reg_t;

  typedef enum logic {
    OP_PAIR = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic {
    KIND_SHELL = 1'b0,
    KIND_BIN   = 1'b1
  } kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fold_status_t;

endpackage

>>> hdl/isc_pair_if.sv
interface isc_pair_if import isc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [SPEC_W-1:0]     species;
  logic [COORD_W-1:0]    ion_x;
  logic [COORD_W-1:0]    ion_y;
  logic [COORD_W-1:0]    ion_z;
  logic [COORD_W-1:0]    oxy_x;
  logic [COORD_W-1:0]    oxy_y;
  logic [COORD_W-1:0]    oxy_z;
  logic                  last_neighbor;
  logic [BSEL_W-1:0]     bin_select;

  modport source (
    output valid, operation, species, ion_x, ion_y, ion_z, oxy_x, oxy_y, oxy_z,
           last_neighbor, bin_select,
    input  ready
  );
  modport sink (
    input  valid, operation, species, ion_x, ion_y, ion_z, oxy_x, oxy_y, oxy_z,
           last_neighbor, bin_select,
    output ready
  );
endinterface

>>> hdl/isc_result_if.sv
interface isc_result_if import isc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [CNT_W-1:0] shell_count;
  logic [CNT_W-1:0] shell_count_inner;
  logic [CNT_W-1:0] shell_count_outer;
  logic             overflow;
  logic [BIN_W-1:0] bin_count;

  modport source (
    output valid, result_kind, shell_count, shell_count_inner, shell_count_outer,
           overflow, bin_count,
    input  ready
  );
  modport sink (
    input  valid, result_kind, shell_count, shell_count_inner, shell_count_outer,
           overflow, bin_count,
    output ready
  );
endinterface

>>> hdl/isc_cfg_if.sv
interface isc_cfg_if import isc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/isc_fold.sv
module isc_fold import isc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  coord_t       ion [AXES],
  input  coord_t       oxy [AXES],
  input  coord_t       len [AXES],
  output coord_t       fold [AXES],
  output fold_status_t status
);

  localparam int STEP_W = $clog2(COORD_W);

  coord_t             diff  [AXES];
  coord_t             rem   [AXES];
  coord_t             len_r [AXES];
  logic [COORD_W:0]   trial [AXES];
  logic [STEP_W-1:0]  step;
  logic               busy;
  logic               done;

  // restoring remainder, one dividend bit per cycle on all three axes
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      trial[a] = {rem[a], diff[a][step]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(COORD_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      if (start) begin
        diff[a]  <= (ion[a] >= oxy[a]) ? ion[a] - oxy[a] : oxy[a] - ion[a];
        rem[a]   <= '0;
        len_r[a] <= len[a];
      end else if (busy) begin
        if (trial[a] >= {1'b0, len_r[a]}) begin
          rem[a] <= COORD_W'(trial[a] - {1'b0, len_r[a]});
        end else begin
          rem[a] <= trial[a][COORD_W-1:0];
        end
      end
    end
  end

  // nearest image: ties go to the far image
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      if (len_r[a] == '0) begin
        fold[a] = diff[a];
      end else if ({rem[a], 1'b0} >= {1'b0, len_r[a]}) begin
        fold[a] = len_r[a] - rem[a];
      end else begin
        fold[a] = rem[a];
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

>>> hdl/isc_hist_mem.sv
module isc_hist_mem import isc_pkg::*; (
  input  logic   clk,
  input  logic   we,
  input  haddr_t waddr,
  input  bin_t   wdata,
  input  haddr_t raddr,
  output bin_t   rdata
);

  bin_t mem [HIST_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ion_shell_count_and_pair_histogram_top.sv
// Ion-oxygen shell counter with a per-species pair-distance histogram. One request
// is handled at a time. A histogram read passes from acceptance through an address
// state and a data state to the result register. A pair passes through acceptance,
// the bit-serial minimum-image remainder unit (one bit of the 24-bit difference per
// cycle), the shared squarer that forms the three squared differences and the three
// squared radii, the compare and, when it lands in the histogram, the bin square
// root and the read-modify-write of the histogram memory. A pair that ends an ion
// then loads the result register; the next request is taken while that result
// waits. After reset the histogram memory is cleared, one bin a cycle, during which
// no request is accepted; configuration writes are accepted at any time.
module ion_shell_count_and_pair_histogram_top import isc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  isc_pair_if.sink    pair,
  isc_result_if.source result,
  isc_cfg_if.sink     cfg
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_ADDR,
    S_RD_DATA,
    S_FOLD,
    S_MUL,
    S_ACC,
    S_CMP,
    S_SQRT,
    S_HRD,
    S_HWR,
    S_FINISH
  } state_t;

  state_t state;

  coord_t box_x, box_y, box_z;
  cut_t   cut_first, cut_second, cut_third;

  cnt_t   run_shell, run_inner, run_outer;

  logic [SPEC_W-1:0] sp_r;
  logic              last_r;
  coord_t            iz_r;
  logic              rd_ok;
  haddr_t            addr_r;
  logic [2:0]        mul_idx;
  logic [PROD_W-1:0] prod;
  logic [RR_W-1:0]   rr;
  logic [SQR_W-1:0]  rc2, lo2, hi2;
  logic [SQV_W-1:0]  sq_v;
  logic [ROOT_W-1:0] root;
  logic [ROOT_STEP_W-1:0] sq_bit;
  kind_t             res_kind;
  bin_t              res_bin;

  logic   res_valid;
  kind_t  out_kind;
  cnt_t   out_shell, out_inner, out_outer;
  logic   out_ovf;
  bin_t   out_bin;

  logic   clearing;
  haddr_t clr_addr;

  logic         accept;
  logic         sp_ok;
  logic         fold_start;
  fold_status_t fold_sts;
  coord_t       ion_c [AXES];
  coord_t       oxy_c [AXES];
  coord_t       len_c [AXES];
  coord_t       fold_m [AXES];

  cut_t              rc;
  rad_t              lo, hi;
  coord_t            sq_op;
  logic              in_slab;
  logic              below_limit;
  logic [SCALED_W-1:0] scaled;
  logic [ROOT_W-1:0] root_try;
  logic [ROOT_W-1:0] root_next;
  logic [ROOT_W-1:0] root_bin;
  haddr_t            base_rd;
  haddr_t            base_sp;

  logic   hist_we;
  haddr_t hist_waddr;
  bin_t   hist_wdata;
  bin_t   hist_q;

  assign accept     = pair.valid && pair.ready;
  assign sp_ok      = pair.species < SPEC_W'(SPECIES_COUNT);
  assign fold_start = accept && (pair.operation == OP_PAIR) && sp_ok;
  assign pair.ready = (state == S_IDLE) && !clearing;
  assign cfg.ready  = 1'b1;

  assign ion_c = '{pair.ion_x, pair.ion_y, pair.ion_z};
  assign oxy_c = '{pair.oxy_x, pair.oxy_y, pair.oxy_z};
  assign len_c = '{box_x, box_y, box_z};

  isc_fold u_fold (
    .clk    (clk),
    .rst    (rst),
    .start  (fold_start),
    .ion    (ion_c),
    .oxy    (oxy_c),
    .len    (len_c),
    .fold   (fold_m),
    .status (fold_sts)
  );

  always_comb begin
    unique case (sp_r)
      SPEC_W'(0): rc = cut_first;
      SPEC_W'(1): rc = cut_second;
      default:    rc = cut_third;
    endcase
    lo = (rc > CUT_W'(TENTH)) ? RAD_W'(rc) - RAD_W'(TENTH) : '0;
    hi = RAD_W'(rc) + RAD_W'(TENTH);
  end

  always_comb begin
    unique case (mul_idx)
      3'd0:    sq_op = fold_m[0];
      3'd1:    sq_op = fold_m[1];
      3'd2:    sq_op = fold_m[2];
      3'd3:    sq_op = COORD_W'(rc);
      3'd4:    sq_op = COORD_W'(lo);
      3'd5:    sq_op = COORD_W'(hi);
      default: sq_op = '0;
    endcase
  end

  assign in_slab     = (iz_r >= SLAB_LO) && (iz_r < SLAB_HI);
  assign below_limit = (rr[RR_W-1:LIMIT_W] == '0) && (rr[LIMIT_W-1:0] < RDF_LIMIT2);
  // 400 = 256 + 128 + 16
  assign scaled = (SCALED_W'(rr[LIMIT_W-1:0]) << 8) + (SCALED_W'(rr[LIMIT_W-1:0]) << 7)
                + (SCALED_W'(rr[LIMIT_W-1:0]) << 4);

  assign root_try  = root | (ROOT_W'(1) << sq_bit);
  assign root_next = (SQV_W'(root_try * root_try) <= sq_v) ? root_try : root;
  assign root_bin  = (root_next > ROOT_W'(DIST_BINS - 1)) ? ROOT_W'(DIST_BINS - 1) : root_next;
  assign base_rd   = HIST_AW'(pair.species) * HIST_AW'(DIST_BINS);
  assign base_sp   = HIST_AW'(sp_r) * HIST_AW'(DIST_BINS);

  assign hist_we    = clearing || (state == S_HWR);
  assign hist_waddr = clearing ? clr_addr : addr_r;
  assign hist_wdata = clearing ? '0 : ((hist_q == '1) ? hist_q : hist_q + 1'b1);

  isc_hist_mem u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (addr_r),
    .rdata (hist_q)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box_x      <= coord_t'(4194304);
      box_y      <= coord_t'(4194304);
      box_z      <= coord_t'(4194304);
      cut_first  <= cut_t'(180224);
      cut_second <= cut_t'(252314);
      cut_third  <= cut_t'(173670);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_BOX_X:      box_x      <= cfg.data[COORD_W-1:0];
        REG_BOX_Y:      box_y      <= cfg.data[COORD_W-1:0];
        REG_BOX_Z:      box_z      <= cfg.data[COORD_W-1:0];
        REG_CUT_FIRST:  cut_first  <= cfg.data[CUT_W-1:0];
        REG_CUT_SECOND: cut_second <= cfg.data[CUT_W-1:0];
        REG_CUT_THIRD:  cut_third  <= cfg.data[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      res_valid <= 1'b0;
      run_shell <= '0;
      run_inner <= '0;
      run_outer <= '0;
    end else begin
      if (clearing) begin
        if (clr_addr == haddr_t'(HIST_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end

      if (res_valid && result.ready && (state != S_FINISH)) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sp_r   <= pair.species;
            last_r <= pair.last_neighbor;
            iz_r   <= pair.ion_z;
            if (pair.operation == OP_READ) begin
              addr_r <= base_rd + HIST_AW'(pair.bin_select);
              rd_ok  <= sp_ok && (pair.bin_select < BSEL_W'(DIST_BINS));
              state  <= S_RD_ADDR;
            end else if (sp_ok) begin
              rr      <= '0;
              mul_idx <= '0;
              state   <= S_FOLD;
            end else if (pair.last_neighbor) begin
              res_kind <= KIND_SHELL;
              state    <= S_FINISH;
            end
          end
        end
        S_RD_ADDR: state <= S_RD_DATA;
        S_RD_DATA: begin
          res_bin  <= rd_ok ? hist_q : '0;
          res_kind <= KIND_BIN;
          state    <= S_FINISH;
        end
        S_FOLD: begin
          if (fold_sts.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= sq_op * sq_op;
          state <= S_ACC;
        end
        S_ACC: begin
          unique case (mul_idx)
            3'd3:    rc2 <= prod[SQR_W-1:0];
            3'd4:    lo2 <= prod[SQR_W-1:0];
            3'd5:    hi2 <= prod[SQR_W-1:0];
            default: rr  <= rr + RR_W'(prod);
          endcase
          if (mul_idx == 3'd5) begin
            state <= S_CMP;
          end else begin
            mul_idx <= mul_idx + 1'b1;
            state   <= S_MUL;
          end
        end
        S_CMP: begin
          if (rr <= RR_W'(rc2) && run_shell != CNT_MAX) run_shell <= run_shell + 1'b1;
          if (rr <= RR_W'(lo2) && run_inner != CNT_MAX) run_inner <= run_inner + 1'b1;
          if (rr <= RR_W'(hi2) && run_outer != CNT_MAX) run_outer <= run_outer + 1'b1;
          if (in_slab && below_limit) begin
            sq_v   <= scaled[2*FRAC_BITS +: SQV_W];
            root   <= '0;
            sq_bit <= ROOT_STEP_W'(ROOT_W - 1);
            state  <= S_SQRT;
          end else if (last_r) begin
            res_kind <= KIND_SHELL;
            state    <= S_FINISH;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SQRT: begin
          root <= root_next;
          if (sq_bit == '0) begin
            addr_r <= base_sp + HIST_AW'(root_bin);
            state  <= S_HRD;
          end else begin
            sq_bit <= sq_bit - 1'b1;
          end
        end
        S_HRD: state <= S_HWR;
        S_HWR: begin
          if (last_r) begin
            res_kind <= KIND_SHELL;
            state    <= S_FINISH;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FINISH: begin
          // hold until the result register is free
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            out_kind  <= res_kind;
            if (res_kind == KIND_SHELL) begin
              out_shell <= run_shell;
              out_inner <= run_inner;
              out_outer <= run_outer;
              out_ovf   <= run_shell[CNT_W-1];
              out_bin   <= '0;
              run_shell <= '0;
              run_inner <= '0;
              run_outer <= '0;
            end else begin
              out_shell <= '0;
              out_inner <= '0;
              out_outer <= '0;
              out_ovf   <= 1'b0;
              out_bin   <= res_bin;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid             = res_valid;
  assign result.result_kind       = out_kind;
  assign result.shell_count       = out_shell;
  assign result.shell_count_inner = out_inner;
  assign result.shell_count_outer = out_outer;
  assign result.overflow          = out_ovf;
  assign result.bin_count         = out_bin;

  a_shell_order: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.result_kind == KIND_SHELL) |->
      (result.shell_count_inner <= result.shell_count) &&
      (result.shell_count <= result.shell_count_outer))
    else $error("shell counts out of radius order");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.result_kind == KIND_SHELL) |->
      result.overflow == result.shell_count[CNT_W-1])
    else $error("overflow flag disagrees with shell count");

  a_bin_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.result_kind == KIND_BIN) |->
      (result.shell_count == '0) && !result.overflow)
    else $error("histogram result carries shell data");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pair.ready)
    else $error("request accepted during histogram clear");

  a_fold_done: assert property (@(posedge clk) disable iff (rst)
    fold_sts.done |-> state == S_FOLD)
    else $error("fold result arrived outside the fold wait");

endmodule

>>> test/ion_shell_count_and_pair_histogram_top_test.sv
module ion_shell_count_and_pair_histogram_top_test import isc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    op_t                 operation;
    logic [SPEC_W-1:0]   species;
    coord_t              ion_x, ion_y, ion_z, oxy_x, oxy_y, oxy_z;
    logic                last_neighbor;
    logic [BSEL_W-1:0]   bin_select;
  } pair_req_t;

  typedef struct {
    kind_t      result_kind;
    cnt_t       shell_count, shell_count_inner, shell_count_outer;
    logic       overflow;
    bin_t       bin_count;
  } shell_res_t;

  typedef struct {
    logic          is_cfg;
    cfg_reg_t      index;
    logic [23:0]   data;
    pair_req_t     req;
  } step_t;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  isc_pair_if   pair ();
  isc_result_if result ();
  isc_cfg_if    cfg ();

  ion_shell_count_and_pair_histogram_top i_dut (
    .clk(clk), .rst(rst), .pair(pair.sink), .result(result.source), .cfg(cfg.sink)
  );

  // predictor state
  logic [23:0] box_len [3];
  logic [18:0] cut_len [3];
  int unsigned cnt_shell, cnt_inner, cnt_outer;
  bin_t        hist [HIST_DEPTH];

  step_t      pending [$];
  shell_res_t expected_results [$];
  int errors = 0;
  int n_pairs = 0, n_reads = 0, n_results = 0, n_binned = 0;
  int idle_quiet = 0;
  int stall_in = 0, stall_out = 0;
  int quiet_cycles = 0;
  bit stim_done = 0;

  function automatic longint unsigned fold_square(longint unsigned a, longint unsigned b,
                                                  longint unsigned len);
    longint unsigned d, m, q, ql;
    d = (a >= b) ? a - b : b - a;
    m = d;
    if (len != 0) begin
      q = (2 * d + len) / (2 * len);
      ql = q * len;
      m = (ql >= d) ? ql - d : d - ql;
    end
    return m * m;
  endfunction

  function automatic int unsigned bin_root(longint unsigned v);
    int unsigned r;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      if (longint'(r | (1 << b)) * longint'(r | (1 << b)) <= v) r = r | (1 << b);
    end
    return r;
  endfunction

  function automatic void predict_pair(pair_req_t p);
    shell_res_t r;
    longint unsigned rr, rc, lo, hi;
    int unsigned k, idx;
    r = '{KIND_SHELL, 0, 0, 0, 0, 0};
    if (p.operation == OP_READ) begin
      r.result_kind = KIND_BIN;
      if (p.species < SPECIES_COUNT && p.bin_select < DIST_BINS)
        r.bin_count = hist[p.species * DIST_BINS + p.bin_select];
      expected_results = {expected_results, r};
      return;
    end
    if (p.species < SPECIES_COUNT) begin
      rr = fold_square(p.oxy_x, p.ion_x, box_len[0]) + fold_square(p.oxy_y, p.ion_y, box_len[1])
         + fold_square(p.oxy_z, p.ion_z, box_len[2]);
      rc = cut_len[p.species];
      lo = (rc > TENTH) ? rc - TENTH : 0;
      hi = rc + TENTH;
      if (rr <= rc * rc && cnt_shell < 63) cnt_shell++;
      if (rr <= lo * lo && cnt_inner < 63) cnt_inner++;
      if (rr <= hi * hi && cnt_outer < 63) cnt_outer++;
      if (p.ion_z >= SLAB_LO && p.ion_z < SLAB_HI && rr < (longint'(36) << 32)) begin
        k = bin_root((400 * rr) >> 32);
        if (k > DIST_BINS - 1) k = DIST_BINS - 1;
        idx = p.species * DIST_BINS + k;
        if (hist[idx] != '1) hist[idx]++;
        n_binned++;
      end
    end
    if (p.last_neighbor) begin
      r.shell_count = cnt_shell;
      r.shell_count_inner = cnt_inner;
      r.shell_count_outer = cnt_outer;
      r.overflow = cnt_shell >= 32;
      expected_results = {expected_results, r};
      cnt_shell = 0;
      cnt_inner = 0;
      cnt_outer = 0;
    end
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: pair and config channels
  always @(posedge clk) begin
    step_t s;
    if (rst) begin
      pair.valid <= 1'b0;
      cfg.valid <= 1'b0;
    end else begin
      if (pair.valid && pair.ready) begin
        s = pending.pop_front();
        predict_pair(s.req);
      end
      if (cfg.valid && cfg.ready) begin
        void'(pending.pop_front());
      end
      if ((pair.valid && !pair.ready) || (cfg.valid && !cfg.ready)) begin
        // hold the request
      end else if (stall_in > 0) begin
        stall_in <= stall_in - 1;
        pair.valid <= 1'b0;
        cfg.valid <= 1'b0;
      end else if (pending.size() > 0 && !pending[0].is_cfg) begin
        cfg.valid <= 1'b0;
        pair.valid <= 1'b1;
        pair.operation <= pending[0].req.operation;
        pair.species <= pending[0].req.species;
        pair.ion_x <= pending[0].req.ion_x;
        pair.ion_y <= pending[0].req.ion_y;
        pair.ion_z <= pending[0].req.ion_z;
        pair.oxy_x <= pending[0].req.oxy_x;
        pair.oxy_y <= pending[0].req.oxy_y;
        pair.oxy_z <= pending[0].req.oxy_z;
        pair.last_neighbor <= pending[0].req.last_neighbor;
        pair.bin_select <= pending[0].req.bin_select;
        if (!idle_quiet && $urandom_range(0, 9) == 0) stall_in <= $urandom_range(1, 3);
      end else if (pending.size() > 0 && pending[0].is_cfg && expected_results.size() == 0
                   && quiet_cycles >= 60) begin
        pair.valid <= 1'b0;
        cfg.valid <= 1'b1;
        cfg.index <= pending[0].index;
        cfg.data <= pending[0].data;
      end else begin
        pair.valid <= 1'b0;
        cfg.valid <= 1'b0;
      end
    end
  end

  // apply a register write to the predictor when the DUT takes it
  always @(posedge clk) begin
    if (!rst && cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_BOX_X:      box_len[0] = cfg.data;
        REG_BOX_Y:      box_len[1] = cfg.data;
        REG_BOX_Z:      box_len[2] = cfg.data;
        REG_CUT_FIRST:  cut_len[0] = cfg.data[18:0];
        REG_CUT_SECOND: cut_len[1] = cfg.data[18:0];
        REG_CUT_THIRD:  cut_len[2] = cfg.data[18:0];
        default: ;
      endcase
    end
  end

  // count cycles since the last pair was accepted, for the idle gap before writes
  always @(posedge clk) begin
    if (rst || (pair.valid && pair.ready)) quiet_cycles <= 0;
    else if (quiet_cycles < 1000) quiet_cycles <= quiet_cycles + 1;
  end

  // monitor
  always @(posedge clk) begin
    shell_res_t w;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", result.result_kind, 0);
        end else begin
          w = expected_results.pop_front();
          if (result.result_kind !== w.result_kind)
            report_mismatch("result_kind", result.result_kind, w.result_kind);
          if (result.shell_count !== w.shell_count)
            report_mismatch("shell_count", result.shell_count, w.shell_count);
          if (result.shell_count_inner !== w.shell_count_inner)
            report_mismatch("shell_count_inner", result.shell_count_inner, w.shell_count_inner);
          if (result.shell_count_outer !== w.shell_count_outer)
            report_mismatch("shell_count_outer", result.shell_count_outer, w.shell_count_outer);
          if (result.overflow !== w.overflow)
            report_mismatch("overflow", result.overflow, w.overflow);
          if (result.bin_count !== w.bin_count)
            report_mismatch("bin_count", result.bin_count, w.bin_count);
        end
      end
      if (stall_out > 0) begin
        stall_out <= stall_out - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        if (!idle_quiet && $urandom_range(0, 7) == 0) stall_out <= $urandom_range(1, 3);
      end
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom_range(0, 24'hFFFFFF));
      1: return '1;
      default: return coord_t'($urandom_range(0, 40 << FRAC_BITS));
    endcase
  endfunction

  function automatic void push_pair(logic [1:0] sp, coord_t ix, coord_t iy, coord_t iz,
                                    coord_t ox, coord_t oy, coord_t oz, logic last);
    step_t s;
    s.is_cfg = 0;
    s.index = REG_BOX_X;
    s.data = 0;
    s.req = '{OP_PAIR, sp, ix, iy, iz, ox, oy, oz, last, 0};
    pending = {pending, s};
  endfunction

  function automatic void push_read(logic [1:0] sp, logic [6:0] b);
    step_t s;
    s.is_cfg = 0;
    s.index = REG_BOX_X;
    s.data = 0;
    s.req = '{OP_READ, sp, 0, 0, 0, 0, 0, 0, $urandom_range(0, 1), b};
    pending = {pending, s};
  endfunction

  function automatic void push_write(cfg_reg_t r, logic [23:0] d);
    step_t s;
    s.is_cfg = 1;
    s.index = r;
    s.data = d;
    s.req = '{OP_PAIR, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    pending = {pending, s};
  endfunction

  // one ion with a run of nearby oxygens, mostly close to the cutoff shell
  function automatic void push_ion(int n, logic [1:0] sp);
    coord_t ix, iy, iz;
    ix = $urandom_range(0, 64 << FRAC_BITS);
    iy = $urandom_range(0, 64 << FRAC_BITS);
    iz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64 << FRAC_BITS)
                                     : $urandom_range(6 << FRAC_BITS, 30 << FRAC_BITS);
    for (int i = 0; i < n; i++)
      push_pair(sp, ix, iy, iz,
                ix + $urandom_range(0, 5 << FRAC_BITS) - (2 << FRAC_BITS),
                iy + $urandom_range(0, 5 << FRAC_BITS) - (2 << FRAC_BITS),
                iz + $urandom_range(0, 5 << FRAC_BITS) - (2 << FRAC_BITS), i == n - 1);
  endfunction

  initial begin
    int total, n;
    box_len = '{24'd4194304, 24'd4194304, 24'd4194304};
    cut_len = '{19'd180224, 19'd252314, 19'd173670};
    cnt_shell = 0;
    cnt_inner = 0;
    cnt_outer = 0;
    foreach (hist[i]) hist[i] = 0;
    pair.valid = 0;
    pair.operation = 0;
    pair.species = 0;
    pair.ion_x = 0;
    pair.ion_y = 0;
    pair.ion_z = 0;
    pair.oxy_x = 0;
    pair.oxy_y = 0;
    pair.oxy_z = 0;
    pair.last_neighbor = 0;
    pair.bin_select = 0;
    cfg.valid = 0;
    cfg.index = REG_BOX_X;
    cfg.data = 0;
    result.ready = 0;

    // directed: extremes, invalid species, out of range reads, zero box length
    push_pair(0, 10 << FRAC_BITS, 10 << FRAC_BITS, 10 << FRAC_BITS,
              10 << FRAC_BITS, 10 << FRAC_BITS, 10 << FRAC_BITS, 0);
    push_pair(0, 10 << FRAC_BITS, 10 << FRAC_BITS, 10 << FRAC_BITS,
              (10 << FRAC_BITS) + 180224, 10 << FRAC_BITS, 10 << FRAC_BITS, 0);
    push_pair(1, 0, 0, 6 << FRAC_BITS, '1, '1, '1, 0);
    push_read(0, 0);
    push_pair(3, 0, 0, 7 << FRAC_BITS, 0, 0, 7 << FRAC_BITS, 1);
    push_pair(2, '1, '1, (30 << FRAC_BITS) - 1, 0, 0, 0, 1);
    push_read(0, 0);
    push_read(3, 0);
    push_read(1, 127);
    push_read(2, 119);
    for (int i = 0; i < 40; i++)
      push_pair(0, 8 << FRAC_BITS, 8 << FRAC_BITS, 8 << FRAC_BITS,
                8 << FRAC_BITS, 8 << FRAC_BITS, 8 << FRAC_BITS, i == 39);
    push_read(0, 0);
    push_write(REG_BOX_X, 0);
    push_write(REG_BOX_Y, 24'hFFFFFF);
    push_write(REG_BOX_Z, 24'd65536);
    push_write(REG_CUT_FIRST, 24'd6554);
    push_write(REG_CUT_SECOND, 24'd393216);
    push_write(REG_CUT_THIRD, 24'd1000);
    push_pair(0, '1, 0, 0, 0, '1, 24'h8000, 1);
    push_pair(2, 0, 0, 8 << FRAC_BITS, 500, 0, 8 << FRAC_BITS, 1);

    total = 0;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        push_write(REG_BOX_X, (phase == 4) ? 24'hFFFFFF : $urandom_range(65536, 24'hFFFFFF));
        push_write(REG_BOX_Y, (phase == 2) ? 0 : $urandom_range(65536, 64 << FRAC_BITS));
        push_write(REG_BOX_Z, (phase == 3) ? 24'd65536 : $urandom_range(65536, 64 << FRAC_BITS));
        push_write(REG_CUT_FIRST, (phase == 3) ? 6554 : $urandom_range(6554, 393216));
        push_write(REG_CUT_SECOND, (phase == 4) ? 393216 : $urandom_range(6554, 393216));
        push_write(REG_CUT_THIRD, $urandom_range(6554, 393216));
      end
      while (total < 150 * (phase + 1)) begin
        case ($urandom_range(0, 9))
          0: begin
            push_pair($urandom_range(0, 3), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 1));
            total++;
          end
          1, 2: begin
            push_read($urandom_range(0, 3), $urandom_range(0, 127));
            total++;
          end
          default: begin
            n = $urandom_range(1, 10);
            push_ion(n, $urandom_range(0, 2));
            total += n;
          end
        endcase
      end
      for (int b = 0; b < 4; b++) push_read($urandom_range(0, 2), $urandom_range(0, 119));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() < 40);
    idle_quiet = 1;
    wait (pending.size() == 0);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
    stim_done = 1;
  end

  // watchdog and end of run
  initial begin
    int idle_run;
    idle_run = 0;
    while (!stim_done && idle_run < WATCHDOG) begin
      @(posedge clk);
      if ((pair.valid && pair.ready) || (result.valid && result.ready)
          || (cfg.valid && cfg.ready))
        idle_run = 0;
      else
        idle_run++;
    end
    if (!stim_done) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("FAIL");
    end else begin
      $display("covered %0d results, %0d pairs binned into the histogram",
               n_results, n_binned);
      if (errors == 0 && expected_results.size() == 0) $display("PASS");
      else $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/isc_pkg.sv
hdl/isc_pair_if.sv
hdl/isc_result_if.sv
hdl/isc_cfg_if.sv
hdl/isc_fold.sv
hdl/isc_hist_mem.sv
hdl/ion_shell_count_and_pair_histogram_top.sv
test/ion_shell_count_and_pair_histogram_top_test.sv
